@@ hw/rtl/i2c_master_bit_sequencer_defines.svh @@
// Assertion macros shared by the sequencer RTL.
// Each macro expects aclk and aresetn to be visible in the module that uses it.
`ifndef I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define I2CMS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// A condition in one cycle that forces another condition in the next cycle.
`define I2CMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/i2cms_pkg.sv @@
`timescale 1ns / 1ps

package i2cms_pkg;

    // Mode codes as they arrive on the input stream.
    localparam logic [2:0] MODE_TICK  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;
    localparam logic [2:0] MODE_ACK   = 3'd5;
    localparam logic [2:0] MODE_NACK  = 3'd6;

    // Phase indexes of the write command after the eight data bits.
    localparam logic [4:0] WR_DATA_PHASES = 5'd24;
    localparam logic [4:0] WR_ACK_SAMPLE  = 5'd25;
    localparam logic [4:0] WR_SCL_LOW     = 5'd26;
    // Last phase of a read that still clocks a data bit.
    localparam logic [4:0] RD_LAST_BIT    = 5'd16;

    // Reciprocal of three in 5-bit fixed point, used to split write phases.
    localparam logic [8:0] RECIP_THREE = 9'd11;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Command being sequenced; the idle code also marks a tick with no command.
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_START = 7'b0000010,
        ST_STOP  = 7'b0000100,
        ST_WRITE = 7'b0001000,
        ST_READ  = 7'b0010000,
        ST_ACK   = 7'b0100000,
        ST_NACK  = 7'b1000000
    } seq_state_t;

    // One classified tick request from the front end.
    typedef struct packed {
        seq_state_t cmd;
        logic [7:0] write_data;
        logic       sda_in;
    } tick_req_t;

    // One result item.
    typedef struct packed {
        logic       rejected;
        logic       gave_up;
        logic       nack_seen;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       scl_drive;
    } tick_res_t;

endpackage

@@ hw/rtl/i2c_master_bit_sequencer.sv @@
// Each tick is queued, then sequenced; its result is registered onto m_axis.
// Throughput: one tick per cycle unless m_axis stalls; one pin phase per tick.
// A two-entry queue between the decoder and the sequencer absorbs output stalls.
// Reset (aresetn low, synchronous) idles the sequencer, drives both pins low,
// and clears the read byte, status flags, retry count and retry limit.
`timescale 1ns / 1ps

module i2c_master_bit_sequencer import i2cms_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] mode, [10:3] write_data, [11] sda_in, [15:12] zero
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] scl_drive, [1] sda_drive, [2] busy_res, [3] done_res, [11:4] read_data,
    // [12] nack_seen, [13] gave_up, [14] rejected, [15] zero
    output logic [15:0] m_axis_tdata
);

    logic      q_full;
    logic      q_push;
    tick_req_t q_push_req;
    logic      q_pop;
    logic      q_valid;
    tick_req_t q_req;
    tick_res_t res;

    i2cms_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_push_req    (q_push_req)
    );

    i2cms_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_req  (q_push_req),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_req   (q_req)
    );

    i2cms_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req_valid (q_valid),
        .req       (q_req),
        .req_pop   (q_pop),
        .out_valid (m_axis_tvalid),
        .out_res   (res),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tdata = {1'b0, res.rejected, res.gave_up, res.nack_seen, res.read_data,
                           res.done_res, res.busy_res, res.sda_drive, res.scl_drive};

endmodule

@@ hw/rtl/i2cms_front.sv @@
`timescale 1ns / 1ps

module i2cms_front import i2cms_pkg::*; (
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        q_full,
    output logic        q_push,
    output tick_req_t   q_push_req
);

    logic [2:0] mode;

    assign mode          = s_axis_tdata[2:0];
    assign s_axis_tready = !q_full;
    assign q_push        = s_axis_tvalid && !q_full;

    // Classify the mode field; plain ticks and the unused code carry no command.
    always_comb begin
        q_push_req.write_data = s_axis_tdata[10:3];
        q_push_req.sda_in     = s_axis_tdata[11];
        case (mode)
            MODE_START: q_push_req.cmd = ST_START;
            MODE_STOP:  q_push_req.cmd = ST_STOP;
            MODE_WRITE: q_push_req.cmd = ST_WRITE;
            MODE_READ:  q_push_req.cmd = ST_READ;
            MODE_ACK:   q_push_req.cmd = ST_ACK;
            MODE_NACK:  q_push_req.cmd = ST_NACK;
            default:    q_push_req.cmd = ST_IDLE;
        endcase
    end

endmodule

@@ hw/rtl/i2cms_queue.sv @@
`timescale 1ns / 1ps

module i2cms_queue import i2cms_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  tick_req_t push_req,
    output logic      full,
    input  logic      pop,
    output logic      pop_valid,
    output tick_req_t pop_req
);

    tick_req_t           entry_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_req   = entry_mem[rd_ptr_reg];

    // Pointer wrap and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_mem[wr_ptr_reg] <= push_req;
        end
    end

endmodule

@@ hw/rtl/i2cms_back.sv @@
`timescale 1ns / 1ps

module i2cms_back import i2cms_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  logic       req_valid,
    input  tick_req_t  req,
    output logic       req_pop,
    output logic       out_valid,
    output tick_res_t  out_res,
    input  logic       out_ready
);

    `include "i2c_master_bit_sequencer_defines.svh"

    seq_state_t  state_reg,   state_next;
    logic [4:0]  phase_reg,   phase_next;
    logic [7:0]  shift_reg,   shift_next;
    logic [7:0]  recv_reg,    recv_next;
    logic        scl_reg,     scl_next;
    logic        sda_reg,     sda_next;
    logic [7:0]  retry_reg,   retry_next;
    logic        nack_reg,    nack_next;
    logic        gave_reg,    gave_next;
    logic [7:0]  limit_reg;
    logic        out_valid_reg;
    tick_res_t   out_res_reg;
    logic        busy;
    logic        done;
    logic        rejected;

    assign req_pop   = req_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    // One bus phase per request: command start, pin update, then advance, resend or finish.
    always_comb begin
        seq_state_t  cur;
        logic [4:0]  p;
        logic        last;
        logic [8:0]  prod;
        logic [2:0]  bit_idx;
        logic [4:0]  rem;
        logic [4:0]  q5;
        logic [2:0]  rd_idx;

        state_next = state_reg;
        phase_next = phase_reg;
        shift_next = shift_reg;
        recv_next  = recv_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        retry_next = retry_reg;
        nack_next  = nack_reg;
        gave_next  = gave_reg;
        busy       = 1'b0;
        done       = 1'b0;
        rejected   = 1'b0;
        last       = 1'b0;
        cur        = state_reg;
        p          = phase_reg;
        prod       = 9'({4'd0, p} * RECIP_THREE);
        bit_idx    = prod[7:5];
        rem        = p - {1'b0, bit_idx, 1'b0} - {2'b00, bit_idx};
        q5         = p - 5'd1;
        rd_idx     = q5[3:1];

        // A command starts only while idle; otherwise it is refused.
        if (state_reg == ST_IDLE) begin
            if (req.cmd != ST_IDLE) begin
                cur = req.cmd;
                p   = '0;
                if (req.cmd == ST_WRITE) begin
                    shift_next = req.write_data;
                    retry_next = '0;
                    nack_next  = 1'b0;
                    gave_next  = 1'b0;
                end
            end
        end else if (req.cmd != ST_IDLE) begin
            rejected = 1'b1;
        end

        // Recompute the write and read phase splits from the effective phase.
        prod    = 9'({4'd0, p} * RECIP_THREE);
        bit_idx = prod[7:5];
        rem     = p - {1'b0, bit_idx, 1'b0} - {2'b00, bit_idx};
        q5      = p - 5'd1;
        rd_idx  = q5[3:1];

        case (cur)
            ST_START: begin
                case (p)
                    5'd0:    sda_next = 1'b1;
                    5'd1:    scl_next = 1'b1;
                    5'd2:    sda_next = 1'b0;
                    default: begin
                        scl_next = 1'b0;
                        last     = 1'b1;
                    end
                endcase
            end
            ST_STOP: begin
                case (p)
                    5'd0:    scl_next = 1'b1;
                    5'd1:    sda_next = 1'b1;
                    5'd2:    scl_next = 1'b0;
                    default: begin
                        sda_next = 1'b0;
                        last     = 1'b1;
                    end
                endcase
            end
            ST_ACK: begin
                case (p)
                    5'd0:    sda_next = 1'b0;
                    5'd1:    scl_next = 1'b1;
                    default: begin
                        scl_next = 1'b0;
                        last     = 1'b1;
                    end
                endcase
            end
            ST_NACK: begin
                case (p)
                    5'd0:    sda_next = 1'b1;
                    5'd1:    scl_next = 1'b1;
                    5'd2:    scl_next = 1'b0;
                    default: begin
                        sda_next = 1'b0;
                        last     = 1'b1;
                    end
                endcase
            end
            ST_WRITE: begin
                if (p < WR_DATA_PHASES) begin
                    // Three phases per data bit: drive SDA, raise SCL, lower SCL.
                    if (rem == 5'd0) begin
                        sda_next = shift_next[3'd7 - bit_idx];
                    end else if (rem == 5'd1) begin
                        scl_next = 1'b1;
                    end else begin
                        scl_next = 1'b0;
                    end
                end else if (p == WR_DATA_PHASES) begin
                    sda_next = 1'b1;
                end else if (p == WR_ACK_SAMPLE) begin
                    scl_next  = 1'b1;
                    nack_next = req.sda_in;
                end else if (p == WR_SCL_LOW) begin
                    scl_next = 1'b0;
                end else begin
                    sda_next = 1'b0;
                    last     = 1'b1;
                end
            end
            ST_READ: begin
                if (p == 5'd0) begin
                    sda_next   = 1'b1;
                    shift_next = '0;
                end else if (p <= RD_LAST_BIT) begin
                    // Even sub-phase raises SCL and samples, odd lowers SCL.
                    if (!q5[0]) begin
                        scl_next = 1'b1;
                        if (req.sda_in) begin
                            shift_next[3'd7 - rd_idx] = 1'b1;
                        end
                    end else begin
                        scl_next = 1'b0;
                    end
                end else begin
                    sda_next  = 1'b0;
                    recv_next = shift_next;
                    last      = 1'b1;
                end
            end
            default: last = 1'b1;
        endcase

        // Advance, resend the byte after a NACK, or finish the command.
        if (cur != ST_IDLE) begin
            if (!last) begin
                phase_next = p + 5'd1;
                busy       = 1'b1;
                state_next = cur;
            end else if (cur == ST_WRITE && nack_next) begin
                if (limit_reg == '0 || retry_next < limit_reg) begin
                    if (retry_next != 8'hFF) begin
                        retry_next = retry_next + 8'd1;
                    end
                    phase_next = '0;
                    busy       = 1'b1;
                    state_next = cur;
                end else begin
                    gave_next  = 1'b1;
                    state_next = ST_IDLE;
                    phase_next = '0;
                    done       = 1'b1;
                end
            end else begin
                state_next = ST_IDLE;
                phase_next = '0;
                done       = 1'b1;
            end
        end
    end

    // Sequencer state and retry limit register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            shift_reg <= '0;
            recv_reg  <= '0;
            scl_reg   <= 1'b0;
            sda_reg   <= 1'b0;
            retry_reg <= '0;
            nack_reg  <= 1'b0;
            gave_reg  <= 1'b0;
            limit_reg <= '0;
        end else begin
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
            if (req_pop) begin
                state_reg <= state_next;
                phase_reg <= phase_next;
                shift_reg <= shift_next;
                recv_reg  <= recv_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                retry_reg <= retry_next;
                nack_reg  <= nack_next;
                gave_reg  <= gave_next;
            end
        end
    end

    // Output register holds one result until the consumer takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (req_pop) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (req_pop) begin
            out_res_reg.scl_drive <= scl_next;
            out_res_reg.sda_drive <= sda_next;
            out_res_reg.busy_res  <= busy;
            out_res_reg.done_res  <= done;
            out_res_reg.read_data <= recv_next;
            out_res_reg.nack_seen <= nack_next;
            out_res_reg.gave_up   <= gave_next;
            out_res_reg.rejected  <= rejected;
        end
    end

    `I2CMS_ASSERT_ALWAYS(a_idle_phase_zero, state_reg != ST_IDLE || phase_reg == '0, "idle with nonzero phase")
    `I2CMS_ASSERT_ALWAYS(a_busy_done_excl, !out_valid_reg || !(out_res_reg.busy_res && out_res_reg.done_res), "busy and done together")
    `I2CMS_ASSERT_NEXT(a_pop_gives_result, req_pop, out_valid_reg, "popped request gave no result")
    `I2CMS_ASSERT_NEXT(a_busy_matches_state, req_pop, (state_reg != ST_IDLE) == out_res_reg.busy_res, "busy flag disagrees with state")

endmodule

@@ tb/i2c_master_bit_sequencer_checker.sv @@
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_checker import i2cms_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // [2:0] mode, [10:3] write_data, [11] sda_in, [15:12] zero
    input  logic [15:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] scl_drive, [1] sda_drive, [2] busy_res, [3] done_res, [11:4] read_data,
    // [12] nack_seen, [13] gave_up, [14] rejected, [15] zero
    input  logic [15:0] m_axis_tdata,
    output int          error_count,
    output int          pending_count,
    output logic        bus_idle
);

    // Shadow copy of the sequencer state; MODE_TICK marks an idle sequencer.
    logic [7:0] retry_limit_q;
    logic [2:0] cmd_q;
    logic [4:0] phase_q;
    logic [7:0] shifter_q;
    logic [7:0] rx_byte_q;
    logic [7:0] retries_q;
    logic       scl_q;
    logic       sda_q;
    logic       nack_q;
    logic       gave_up_q;

    // Pin and status values still owed by the block, oldest first.
    tick_res_t  pin_results_q[$];

    // Count a mismatch and report only the first ten in detail.
    task automatic note_mismatch(input string what, input int exp_v, input int act_v);
        error_count++;
        if (error_count <= 10)
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, what, exp_v, act_v);
    endtask

    // Advance the shadow sequencer by one bus tick and produce its pin result.
    task automatic step_bus_tick(input logic [2:0] mode, input logic [7:0] wdata,
                                 input logic sda_in, output tick_res_t res);
        logic is_cmd;
        logic last;
        int   bit_pos;
        int   sub_phase;
        is_cmd = (mode >= MODE_START) && (mode <= MODE_NACK);
        res = '0;
        last = 1'b0;

        // A command is taken only by an idle sequencer; otherwise it is refused.
        if (cmd_q == MODE_TICK) begin
            if (is_cmd) begin
                cmd_q = mode;
                phase_q = '0;
                if (mode == MODE_WRITE) begin
                    shifter_q = wdata;
                    retries_q = '0;
                    nack_q = 1'b0;
                    gave_up_q = 1'b0;
                end
            end
        end else if (is_cmd) begin
            res.rejected = 1'b1;
        end

        if (cmd_q != MODE_TICK) begin
            case (cmd_q)
                MODE_START: begin
                    case (phase_q)
                        5'd0: sda_q = 1'b1;
                        5'd1: scl_q = 1'b1;
                        5'd2: sda_q = 1'b0;
                        default: begin
                            scl_q = 1'b0;
                            last = 1'b1;
                        end
                    endcase
                end
                MODE_STOP: begin
                    case (phase_q)
                        5'd0: scl_q = 1'b1;
                        5'd1: sda_q = 1'b1;
                        5'd2: scl_q = 1'b0;
                        default: begin
                            sda_q = 1'b0;
                            last = 1'b1;
                        end
                    endcase
                end
                MODE_ACK: begin
                    case (phase_q)
                        5'd0: sda_q = 1'b0;
                        5'd1: scl_q = 1'b1;
                        default: begin
                            scl_q = 1'b0;
                            last = 1'b1;
                        end
                    endcase
                end
                MODE_NACK: begin
                    case (phase_q)
                        5'd0: sda_q = 1'b1;
                        5'd1: scl_q = 1'b1;
                        5'd2: scl_q = 1'b0;
                        default: begin
                            sda_q = 1'b0;
                            last = 1'b1;
                        end
                    endcase
                end
                MODE_WRITE: begin
                    // Each data bit takes three phases: SDA set, SCL high, SCL low.
                    if (phase_q < WR_DATA_PHASES) begin
                        bit_pos = 7 - (int'(phase_q) / 3);
                        sub_phase = int'(phase_q) % 3;
                        if (sub_phase == 0)
                            sda_q = shifter_q[bit_pos];
                        else if (sub_phase == 1)
                            scl_q = 1'b1;
                        else
                            scl_q = 1'b0;
                    end else if (phase_q == WR_DATA_PHASES) begin
                        sda_q = 1'b1;
                    end else if (phase_q == WR_ACK_SAMPLE) begin
                        scl_q = 1'b1;
                        nack_q = sda_in;
                    end else if (phase_q == WR_SCL_LOW) begin
                        scl_q = 1'b0;
                    end else begin
                        sda_q = 1'b0;
                        last = 1'b1;
                    end
                end
                MODE_READ: begin
                    // Bits are sampled MSB first on the SCL-high phases.
                    if (phase_q == 5'd0) begin
                        sda_q = 1'b1;
                        shifter_q = '0;
                    end else if (phase_q <= RD_LAST_BIT) begin
                        bit_pos = 7 - ((int'(phase_q) - 1) / 2);
                        if (phase_q[0]) begin
                            scl_q = 1'b1;
                            if (sda_in)
                                shifter_q[bit_pos] = 1'b1;
                        end else begin
                            scl_q = 1'b0;
                        end
                    end else begin
                        sda_q = 1'b0;
                        rx_byte_q = shifter_q;
                        last = 1'b1;
                    end
                end
                default: last = 1'b1;
            endcase

            // After the last phase, a refused write byte is resent while retries remain.
            if (!last) begin
                phase_q = phase_q + 5'd1;
                res.busy_res = 1'b1;
            end else if (cmd_q == MODE_WRITE && nack_q) begin
                if (retry_limit_q == 8'd0 || retries_q < retry_limit_q) begin
                    if (retries_q != 8'hFF)
                        retries_q = retries_q + 8'd1;
                    phase_q = '0;
                    res.busy_res = 1'b1;
                end else begin
                    gave_up_q = 1'b1;
                    cmd_q = MODE_TICK;
                    phase_q = '0;
                    res.done_res = 1'b1;
                end
            end else begin
                cmd_q = MODE_TICK;
                phase_q = '0;
                res.done_res = 1'b1;
            end
        end

        res.scl_drive = scl_q;
        res.sda_drive = sda_q;
        res.read_data = rx_byte_q;
        res.nack_seen = nack_q;
        res.gave_up = gave_up_q;
    endtask

    // Compare one result field by field against its prediction.
    task automatic compare_pins(input tick_res_t exp_r, input tick_res_t act_r);
        if (act_r.scl_drive !== exp_r.scl_drive)
            note_mismatch("scl_drive", exp_r.scl_drive, act_r.scl_drive);
        if (act_r.sda_drive !== exp_r.sda_drive)
            note_mismatch("sda_drive", exp_r.sda_drive, act_r.sda_drive);
        if (act_r.busy_res !== exp_r.busy_res)
            note_mismatch("busy_res", exp_r.busy_res, act_r.busy_res);
        if (act_r.done_res !== exp_r.done_res)
            note_mismatch("done_res", exp_r.done_res, act_r.done_res);
        if (act_r.read_data !== exp_r.read_data)
            note_mismatch("read_data", exp_r.read_data, act_r.read_data);
        if (act_r.nack_seen !== exp_r.nack_seen)
            note_mismatch("nack_seen", exp_r.nack_seen, act_r.nack_seen);
        if (act_r.gave_up !== exp_r.gave_up)
            note_mismatch("gave_up", exp_r.gave_up, act_r.gave_up);
        if (act_r.rejected !== exp_r.rejected)
            note_mismatch("rejected", exp_r.rejected, act_r.rejected);
    endtask

    // Results are checked before the same edge's request is predicted.
    always @(posedge aclk) begin
        tick_res_t pred;
        if (!aresetn) begin
            retry_limit_q = '0;
            cmd_q = MODE_TICK;
            phase_q = '0;
            shifter_q = '0;
            rx_byte_q = '0;
            retries_q = '0;
            scl_q = 1'b0;
            sda_q = 1'b0;
            nack_q = 1'b0;
            gave_up_q = 1'b0;
            error_count = 0;
            pin_results_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pin_results_q.size() == 0)
                    note_mismatch("result with no request waiting", 0, m_axis_tdata);
                else
                    compare_pins(pin_results_q.pop_front(), tick_res_t'(m_axis_tdata[14:0]));
            end
            if (cfg_we)
                retry_limit_q = cfg_wdata;
            if (s_axis_tvalid && s_axis_tready) begin
                step_bus_tick(s_axis_tdata[2:0], s_axis_tdata[10:3], s_axis_tdata[11], pred);
                pin_results_q.push_back(pred);
            end
        end
        pending_count = pin_results_q.size();
        bus_idle = (cmd_q == MODE_TICK);
    end

endmodule

@@ tb/i2c_master_bit_sequencer_test.sv @@
`timescale 1ns / 1ps

module i2c_master_bit_sequencer_test import i2cms_pkg::*;;

    // Mode 7 carries no command and must be treated as a plain tick.
    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam int HOLD_CYCLES = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [7:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    int   error_count;
    int   pending_count;
    logic bus_idle;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int items_sent = 0;

    always #2 aclk = ~aclk;

    i2c_master_bit_sequencer u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    i2c_master_bit_sequencer_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .error_count   (error_count),
        .pending_count (pending_count),
        .bus_idle      (bus_idle)
    );

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    always @(negedge aclk) begin
        if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Offer one tick request, with random gaps, and wait until it is taken.
    task automatic send_tick(input logic [2:0] mode, input logic [7:0] wdata,
                             input logic sda_in);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, sda_in, wdata, mode};
        @(posedge aclk);
        while (!s_axis_tready)
            @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // Start a command and keep ticking until the sequencer is idle again.
    // sda_one_pct sets how often SDA reads high; noise_pct how often a tick
    // carries a stray mode code, which must be refused when it names a command.
    task automatic run_command(input logic [2:0] mode, input logic [7:0] wdata,
                               input int sda_one_pct, input int noise_pct);
        logic [2:0] tick_mode;
        send_tick(mode, wdata, $urandom_range(99) < sda_one_pct);
        while (!bus_idle) begin
            tick_mode = ($urandom_range(99) < noise_pct) ? 3'($urandom_range(7, 1)) : MODE_TICK;
            send_tick(tick_mode, 8'($urandom_range(255)), $urandom_range(99) < sda_one_pct);
        end
    endtask

    // Mostly complete commands with random content, some idle ticks between.
    task automatic random_traffic(input int count);
        int first_item;
        first_item = items_sent;
        while (items_sent - first_item < count) begin
            if ($urandom_range(9) == 0)
                send_tick($urandom_range(1) ? MODE_TICK : MODE_UNUSED,
                          8'($urandom_range(255)), 1'($urandom_range(1)));
            else
                run_command(3'($urandom_range(MODE_NACK, MODE_START)),
                            8'($urandom_range(255)), 40, 8);
        end
    endtask

    // Let every result drain, then write the retry limit while the block is idle.
    task automatic drain_and_set_limit(input logic [7:0] limit);
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= limit;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Short commands, idle ticks, the unused mode and refused commands.
        drain_and_set_limit(8'd1);
        run_command(MODE_START, 8'h00, 50, 0);
        run_command(MODE_STOP, 8'hFF, 50, 0);
        run_command(MODE_ACK, 8'h00, 50, 0);
        run_command(MODE_NACK, 8'hFF, 50, 0);
        send_tick(MODE_TICK, 8'h00, 1'b0);
        send_tick(MODE_UNUSED, 8'hFF, 1'b1);
        run_command(MODE_START, 8'h00, 50, 100);

        // Byte extremes: a write that gives up after one resend, a clean write,
        // and reads of all ones and all zeros.
        run_command(MODE_WRITE, 8'hFF, 100, 0);
        run_command(MODE_WRITE, 8'h00, 0, 0);
        run_command(MODE_READ, 8'h00, 100, 0);
        run_command(MODE_READ, 8'hFF, 0, 0);
        random_traffic(35);

        // Unlimited resends with a sender that idles often.
        drain_and_set_limit(8'd0);
        send_idle_pct = 59;
        random_traffic(35);

        // Highest limit; the receiver stalls and once holds off for a long time.
        drain_and_set_limit(8'd255);
        send_idle_pct = 0;
        stall_pct = 59;
        hold_requests++;
        random_traffic(35);

        // Small limit with both sides idling; one write runs out of resends.
        drain_and_set_limit(8'd3);
        send_idle_pct = 19;
        stall_pct = 19;
        run_command(MODE_WRITE, 8'h5A, 100, 0);
        random_traffic(35);

        // Back to unlimited at full rate.
        drain_and_set_limit(8'd0);
        send_idle_pct = 0;
        stall_pct = 0;
        random_traffic(35);

        s_axis_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
